>>> src/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, character codes and tables for the local size scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

  localparam int CFG_WIDTH  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 104;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INV = 2'd3;

  localparam logic [31:0] RST_MAX_X   = 32'd1024;
  localparam logic [31:0] RST_MAX_Y   = 32'd1024;
  localparam logic [31:0] RST_MAX_Z   = 32'd64;
  localparam logic [31:0] RST_MAX_INV = 32'd1024;

  // verdict codes
  localparam logic [1:0] VERDICT_NONE   = 2'd0;
  localparam logic [1:0] VERDICT_OK     = 2'd1;
  localparam logic [1:0] VERDICT_AXIS   = 2'd2;
  localparam logic [1:0] VERDICT_INVOKE = 2'd3;

  // matcher positions
  localparam logic [4:0] PREFIX_LEN  = 5'd11;
  localparam logic [4:0] POS_LOCAL_L = 5'd5;
  localparam logic [4:0] POS_AXIS    = 5'd11;
  localparam logic [4:0] POS_WS_PRE  = 5'd12;
  localparam logic [4:0] POS_WS_POST = 5'd13;
  localparam logic [4:0] POS_DIGITS  = 5'd14;

  // character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Y     = 8'h79;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STAR   = 3'd4
  } mode_t;

  typedef struct packed {
    logic accept;
    logic scan_second;
    logic flush;
    logic mul1;
    logic mul2;
    logic report;
  } dp_cmd_t;

  typedef struct packed {
    logic two_emit;
  } dp_status_t;

  // pattern prefix text, one character per position
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h6C;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h63;
      4'd3:    c = 8'h61;
      4'd4:    c = 8'h6C;
      4'd5:    c = 8'h5F;
      4'd6:    c = 8'h73;
      4'd7:    c = 8'h69;
      4'd8:    c = 8'h7A;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h5F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

endpackage

`default_nettype wire

>>> src/compute_local_size_scanner.sv
// ----------------------------------------------------------------------------
// compute_local_size_scanner
// Streams shader source bytes, blanks comments and reports the declared
// compute work group size with a limit verdict on the last byte.
// ----------------------------------------------------------------------------
// A byte that releases two blanked characters (the byte after a held '/',
// or a byte after a held '*' inside a block comment that is anything but
// another '*') needs an extra scan step for its second character, since the
// single matcher consumes one character per cycle. After the last byte come
// the flush of a held character, two 32x32 multiply steps for the exact
// x*y*z product and the verdict, before the result is loaded into the output
// register, plus any wait for that register to drain. The next source may
// be fed while a result waits. The user must write limit registers through
// the cfg port only while no source is in progress; the block does not check.
`default_nettype none

module compute_local_size_scanner #(
  parameter int SIZE_BITS = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [lss_pkg::IN_DATA_W-1:0]      in_tdata,   // [7:0] ch
  input  wire                                in_tlast,   // last_char
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // [1:0] verdict, [33:2] size_x, [65:34] size_y, [97:66] size_z, rest zero
  output logic [lss_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire                                cfg_wr_en,
  input  wire  [lss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [lss_pkg::CFG_WIDTH-1:0]      cfg_wdata
);

  lss_pkg::dp_cmd_t    cmd;
  lss_pkg::dp_status_t status;

  lss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  lss_datapath #(
    .SIZE_BITS (SIZE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_ch     (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

>>> src/lss_ctrl.sv
// ----------------------------------------------------------------------------
// lss_ctrl
// Sequencer: input handshake, second-character scan, end-of-source flush,
// product check steps and result register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire                 in_tlast,
  output logic                out_tvalid,
  input  wire                 out_tready,
  input  lss_pkg::dp_status_t status,
  output lss_pkg::dp_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN1 = 6'b000010,
    ST_FLUSH = 6'b000100,
    ST_MUL1  = 6'b001000,
    ST_MUL2  = 6'b010000,
    ST_JUDGE = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (status.two_emit) begin
            state_nxt = ST_SCAN1;
          end else if (in_tlast) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_SCAN1: begin
        cmd.scan_second = 1'b1;
        state_nxt = last_r ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = ST_JUDGE;
      end
      ST_JUDGE: begin
        // result register must be free or draining this cycle
        if (!out_valid_r || out_tready) begin
          cmd.report = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign last_nxt = cmd.accept ? in_tlast : last_r;

  always_comb begin
    if (cmd.report) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_last_goes_to_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (state_r == ST_SCAN1 || state_r == ST_FLUSH))
    else $error("last byte did not lead to the flush step");

  a_report_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report |=> out_valid_r)
    else $error("report did not raise out_tvalid");

  a_flush_to_judge: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |=> ##2 (state_r == ST_JUDGE))
    else $error("product steps out of sequence");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> out_valid_r)
    else $error("pending result dropped");
`endif

endmodule

`default_nettype wire

>>> src/lss_datapath.sv
// ----------------------------------------------------------------------------
// lss_datapath
// Comment blanking, pattern matcher, digit accumulator, size store,
// limit registers, product check and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_datapath #(
  parameter int SIZE_BITS = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  lss_pkg::dp_cmd_t                     cmd,
  output lss_pkg::dp_status_t                  status,
  input  wire  [lss_pkg::IN_DATA_W-1:0]        in_ch,
  input  wire                                  cfg_wr_en,
  input  wire  [lss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [lss_pkg::CFG_WIDTH-1:0]        cfg_wdata,
  output logic [lss_pkg::OUT_DATA_W-1:0]       out_data
);

  localparam logic [SIZE_BITS-1:0] SIZE_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

  lss_pkg::mode_t mode_r, mode_nxt;
  logic [4:0]           pos_r, pos_nxt;
  logic [1:0]           axis_r, axis_nxt;
  logic [SIZE_BITS-1:0] acc_r, acc_nxt;
  logic                 declared_r, declared_nxt;
  logic [SIZE_BITS-1:0] size_r [3];
  logic [7:0]           pend_r;

  logic [31:0] max_x_r, max_y_r, max_z_r, max_inv_r;

  logic [2*SIZE_BITS-1:0] xy_r;
  logic [63:0]            xyz_r;
  logic                   xy_zero_r;
  logic                   xy_over_r;
  logic [lss_pkg::OUT_DATA_W-1:0] out_data_r;

  // comment blanking of the incoming byte
  logic [1:0]     strip_n;
  logic [7:0]     strip_e0, strip_e1;
  lss_pkg::mode_t strip_mode;
  logic [7:0]     blk_c;

  always_comb begin
    blk_c      = (in_ch == lss_pkg::CH_NL) ? lss_pkg::CH_NL : lss_pkg::CH_SPACE;
    strip_n    = 2'd1;
    strip_e0   = lss_pkg::CH_SPACE;
    strip_e1   = lss_pkg::CH_SPACE;
    strip_mode = mode_r;
    case (mode_r)
      lss_pkg::MODE_SLASH: begin
        strip_n = 2'd2;
        if (in_ch == lss_pkg::CH_SLASH) begin
          strip_mode = lss_pkg::MODE_LINE;
        end else if (in_ch == lss_pkg::CH_STAR) begin
          strip_mode = lss_pkg::MODE_BLOCK;
        end else begin
          strip_e0   = lss_pkg::CH_SLASH;
          strip_e1   = in_ch;
          strip_mode = lss_pkg::MODE_NORMAL;
        end
      end
      lss_pkg::MODE_LINE: begin
        if (in_ch == lss_pkg::CH_NL) begin
          strip_e0   = lss_pkg::CH_NL;
          strip_mode = lss_pkg::MODE_NORMAL;
        end
      end
      lss_pkg::MODE_BLOCK: begin
        if (in_ch == lss_pkg::CH_STAR) begin
          strip_n    = 2'd0;
          strip_mode = lss_pkg::MODE_STAR;
        end else begin
          strip_e0 = blk_c;
        end
      end
      lss_pkg::MODE_STAR: begin
        // held star: closes the comment, stays held on another star, or turns into a blank
        if (in_ch == lss_pkg::CH_SLASH) begin
          strip_n    = 2'd2;
          strip_mode = lss_pkg::MODE_NORMAL;
        end else if (in_ch == lss_pkg::CH_STAR) begin
          strip_mode = lss_pkg::MODE_STAR;
        end else begin
          strip_n    = 2'd2;
          strip_e1   = blk_c;
          strip_mode = lss_pkg::MODE_BLOCK;
        end
      end
      default: begin
        if (in_ch == lss_pkg::CH_SLASH) begin
          strip_n    = 2'd0;
          strip_mode = lss_pkg::MODE_SLASH;
        end else begin
          strip_e0   = in_ch;
          strip_mode = lss_pkg::MODE_NORMAL;
        end
      end
    endcase
  end

  assign status.two_emit = (strip_n == 2'd2);

  // pick the character for the matcher this cycle
  logic       scan_en;
  logic [7:0] scan_c;
  logic       commit_only;

  always_comb begin
    scan_en     = 1'b0;
    scan_c      = lss_pkg::CH_SPACE;
    commit_only = 1'b0;
    if (cmd.accept) begin
      scan_en = (strip_n != 2'd0);
      scan_c  = strip_e0;
    end else if (cmd.scan_second) begin
      scan_en = 1'b1;
      scan_c  = pend_r;
    end else if (cmd.flush) begin
      if (mode_r == lss_pkg::MODE_SLASH) begin
        scan_en = 1'b1;
        scan_c  = lss_pkg::CH_SLASH;
      end else if (mode_r == lss_pkg::MODE_STAR) begin
        scan_en = 1'b1;
      end else begin
        commit_only = (pos_r == lss_pkg::POS_DIGITS);
      end
    end
  end

  // pattern matcher
  logic [4:0]           restart_pos;
  logic [SIZE_BITS+3:0] acc_x10;
  logic                 scan_commit;

  always_comb begin
    restart_pos  = (scan_c == lss_pkg::CH_L) ? 5'd1 : 5'd0;
    acc_x10      = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
                   + {{SIZE_BITS{1'b0}}, scan_c[3:0]};
    pos_nxt      = pos_r;
    axis_nxt     = axis_r;
    acc_nxt      = acc_r;
    declared_nxt = declared_r;
    scan_commit  = 1'b0;
    if (scan_en) begin
      if (pos_r < lss_pkg::PREFIX_LEN) begin
        if (scan_c == lss_pkg::prefix_char(pos_r[3:0])) begin
          pos_nxt = pos_r + 5'd1;
        end else if (pos_r == lss_pkg::POS_LOCAL_L && scan_c == lss_pkg::CH_O) begin
          pos_nxt = 5'd2;  // "lo" after "local" restarts mid-prefix
        end else begin
          pos_nxt = restart_pos;
        end
      end else if (pos_r == lss_pkg::POS_AXIS) begin
        if (scan_c == lss_pkg::CH_X || scan_c == lss_pkg::CH_Y ||
            scan_c == lss_pkg::CH_Z) begin
          axis_nxt = 2'(scan_c - lss_pkg::CH_X);
          pos_nxt  = lss_pkg::POS_WS_PRE;
        end else begin
          pos_nxt = restart_pos;
        end
      end else if (pos_r == lss_pkg::POS_WS_PRE) begin
        if (scan_c == lss_pkg::CH_EQ) begin
          pos_nxt = lss_pkg::POS_WS_POST;
        end else if (!lss_pkg::is_space(scan_c)) begin
          pos_nxt = restart_pos;
        end
      end else if (pos_r == lss_pkg::POS_WS_POST) begin
        if (lss_pkg::is_digit(scan_c)) begin
          acc_nxt      = {{(SIZE_BITS-4){1'b0}}, scan_c[3:0]};
          declared_nxt = 1'b1;
          pos_nxt      = lss_pkg::POS_DIGITS;
        end else if (!lss_pkg::is_space(scan_c)) begin
          pos_nxt = restart_pos;
        end
      end else if (pos_r == lss_pkg::POS_DIGITS) begin
        if (lss_pkg::is_digit(scan_c)) begin
          if (acc_x10[SIZE_BITS+3:SIZE_BITS] != 4'd0) begin
            acc_nxt = '1;
          end else begin
            acc_nxt = acc_x10[SIZE_BITS-1:0];
          end
        end else begin
          scan_commit = 1'b1;
          pos_nxt     = restart_pos;
        end
      end else begin
        pos_nxt = restart_pos;
      end
    end
  end

  always_comb begin
    if (cmd.report) begin
      mode_nxt = lss_pkg::MODE_NORMAL;
    end else if (cmd.accept) begin
      mode_nxt = strip_mode;
    end else begin
      mode_nxt = mode_r;
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.report) begin
      mode_r     <= lss_pkg::MODE_NORMAL;
      pos_r      <= 5'd0;
      axis_r     <= 2'd0;
      acc_r      <= '0;
      declared_r <= 1'b0;
      size_r[0]  <= SIZE_ONE;
      size_r[1]  <= SIZE_ONE;
      size_r[2]  <= SIZE_ONE;
    end else begin
      mode_r     <= mode_nxt;
      pos_r      <= pos_nxt;
      axis_r     <= axis_nxt;
      acc_r      <= acc_nxt;
      declared_r <= declared_nxt;
      if (scan_commit || commit_only) begin
        case (axis_r)
          2'd0:    size_r[0] <= acc_r;
          2'd1:    size_r[1] <= acc_r;
          2'd2:    size_r[2] <= acc_r;
          default: size_r[0] <= size_r[0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_r <= strip_e1;
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r   <= lss_pkg::RST_MAX_X;
      max_y_r   <= lss_pkg::RST_MAX_Y;
      max_z_r   <= lss_pkg::RST_MAX_Z;
      max_inv_r <= lss_pkg::RST_MAX_INV;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lss_pkg::REG_MAX_X:   max_x_r   <= cfg_wdata;
        lss_pkg::REG_MAX_Y:   max_y_r   <= cfg_wdata;
        lss_pkg::REG_MAX_Z:   max_z_r   <= cfg_wdata;
        lss_pkg::REG_MAX_INV: max_inv_r <= cfg_wdata;
        default:              max_x_r   <= max_x_r;
      endcase
    end
  end

  // product check: x*y, then (x*y)*z from the low 32 bits of x*y, used only when x*y is within the limit
  logic [31:0] xy32, z32;
  assign xy32 = 32'(xy_r);
  assign z32  = 32'(size_r[2]);

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      xy_r <= size_r[0] * size_r[1];
    end
    if (cmd.mul2) begin
      xy_zero_r <= (xy_r == '0);
      xy_over_r <= (64'(xy_r) > {32'd0, max_inv_r});
      xyz_r     <= xy32 * z32;
    end
  end

  logic [1:0] verdict;
  logic       axis_over;

  always_comb begin
    axis_over = (32'(size_r[0]) > max_x_r) || (32'(size_r[1]) > max_y_r) ||
                (z32 > max_z_r);
    if (!declared_r) begin
      verdict = lss_pkg::VERDICT_NONE;
    end else if (axis_over) begin
      verdict = lss_pkg::VERDICT_AXIS;
    end else if (xy_zero_r || z32 == 32'd0) begin
      verdict = lss_pkg::VERDICT_OK;
    end else if (xy_over_r || xyz_r > {32'd0, max_inv_r}) begin
      verdict = lss_pkg::VERDICT_INVOKE;
    end else begin
      verdict = lss_pkg::VERDICT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_data_r <= {6'd0, z32, 32'(size_r[1]), 32'(size_r[0]), verdict};
    end
  end

  assign out_data = out_data_r;

endmodule

`default_nettype wire

>>> verif/tb_compute_local_size_scanner.sv
// ----------------------------------------------------------------------------
// tb_compute_local_size_scanner
// Streams shader sources into the scanner: work group size declarations,
// comments of both kinds, stray slashes and stars, malformed patterns and raw
// bytes. Random gaps and stalls are applied on both sides, and the limit
// registers are changed between batches. A scanner model inside the bench
// predicts every report, and each report is checked field by field as it is
// taken.
// ----------------------------------------------------------------------------
module tb_compute_local_size_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int TARGET_BYTES  = 2000;

  typedef enum logic [1:0] {
    JOB_BYTE = 2'd0,
    JOB_SYNC = 2'd1,
    JOB_CFG  = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t                     kind;
    logic [7:0]                    ch;
    logic                          last;
    logic                          paced;
    logic [lss_pkg::CFG_IDX_W-1:0] idx;
    logic [lss_pkg::CFG_WIDTH-1:0] val;
  } job_t;

  typedef struct packed {
    logic [1:0]  verdict;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } report_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  wire                            in_tready;
  logic [lss_pkg::IN_DATA_W-1:0]  in_tdata   = '0;   // [7:0] ch
  logic                           in_tlast   = 1'b0; // last_char
  wire                            out_tvalid;
  logic                           out_tready = 1'b0;
  // [1:0] verdict, [33:2] size_x, [65:34] size_y, [97:66] size_z, rest zero
  wire [lss_pkg::OUT_DATA_W-1:0]  out_tdata;
  logic                           cfg_wr_en  = 1'b0;
  logic [lss_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [lss_pkg::CFG_WIDTH-1:0]  cfg_wdata  = '0;

  compute_local_size_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // scanner model state
  lss_pkg::mode_t blank_mode  = lss_pkg::MODE_NORMAL;
  logic [4:0]     pat_pos     = '0;
  logic [1:0]     cur_axis    = '0;
  logic [31:0]    acc         = '0;
  logic [31:0]    axis_val [3] = '{32'd1, 32'd1, 32'd1};
  logic           seen_decl   = 1'b0;
  logic [31:0]    lim_x       = lss_pkg::RST_MAX_X;
  logic [31:0]    lim_y       = lss_pkg::RST_MAX_Y;
  logic [31:0]    lim_z       = lss_pkg::RST_MAX_Z;
  logic [31:0]    lim_inv     = lss_pkg::RST_MAX_INV;
  string          keyword     = {"local", "_size_"};

  report_t    pending_reports[$];
  job_t       work_q[$];
  logic [7:0] src_buf[$];

  int   mismatches   = 0;
  int   results_seen = 0;
  int   cycles       = 0;
  int   byte_total   = 0;
  logic byte_taken   = 1'b0;

  int   gap_left      = 0;
  int   settle_left   = 0;
  int   stall_left    = 0;
  int   hold_left     = 0;
  logic hold_done     = 1'b0;
  int   rx_phase_left = 0;
  logic rx_calm       = 1'b0;

  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 40);
  endfunction

  function automatic logic ws_char(input logic [7:0] c);
    return (c == lss_pkg::CH_SPACE) || (c >= lss_pkg::CH_TAB && c <= lss_pkg::CH_CR);
  endfunction

  function automatic logic dec_char(input logic [7:0] c);
    return (c >= lss_pkg::CH_0) && (c <= lss_pkg::CH_9);
  endfunction

  task automatic clear_scan();
    blank_mode  = lss_pkg::MODE_NORMAL;
    pat_pos     = '0;
    cur_axis    = '0;
    acc         = '0;
    axis_val[0] = 32'd1;
    axis_val[1] = 32'd1;
    axis_val[2] = 32'd1;
    seen_decl   = 1'b0;
  endtask

  task automatic restart_on(input logic [7:0] c);
    pat_pos = (c == lss_pkg::CH_L) ? 5'd1 : 5'd0;
  endtask

  // pattern matcher, one blanked character at a time
  task automatic match_char(input logic [7:0] c);
    logic [63:0] grown;
    if (pat_pos < lss_pkg::PREFIX_LEN) begin
      if (c == keyword[pat_pos]) begin
        pat_pos = pat_pos + 5'd1;
      end else if (pat_pos == lss_pkg::POS_LOCAL_L && c == lss_pkg::CH_O) begin
        pat_pos = 5'd2;  // "localo..." may still start a new "local"
      end else begin
        restart_on(c);
      end
    end else if (pat_pos == lss_pkg::POS_AXIS) begin
      if (c == lss_pkg::CH_X || c == lss_pkg::CH_Y || c == lss_pkg::CH_Z) begin
        cur_axis = 2'(c - lss_pkg::CH_X);
        pat_pos  = lss_pkg::POS_WS_PRE;
      end else begin
        restart_on(c);
      end
    end else if (pat_pos == lss_pkg::POS_WS_PRE) begin
      if (c == lss_pkg::CH_EQ) begin
        pat_pos = lss_pkg::POS_WS_POST;
      end else if (!ws_char(c)) begin
        restart_on(c);
      end
    end else if (pat_pos == lss_pkg::POS_WS_POST) begin
      if (dec_char(c)) begin
        acc       = 32'(c - lss_pkg::CH_0);
        seen_decl = 1'b1;
        pat_pos   = lss_pkg::POS_DIGITS;
      end else if (!ws_char(c)) begin
        restart_on(c);
      end
    end else if (pat_pos == lss_pkg::POS_DIGITS) begin
      if (dec_char(c)) begin
        grown = {32'd0, acc} * 64'd10 + {56'd0, c - lss_pkg::CH_0};
        acc   = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
      end else begin
        axis_val[cur_axis] = acc;
        restart_on(c);
      end
    end else begin
      restart_on(c);
    end
  endtask

  // comment blanking; a slash or a star at a comment edge is held one byte
  task automatic strip_char(input logic [7:0] c);
    case (blank_mode)
      lss_pkg::MODE_SLASH: begin
        if (c == lss_pkg::CH_SLASH || c == lss_pkg::CH_STAR) begin
          match_char(lss_pkg::CH_SPACE);
          match_char(lss_pkg::CH_SPACE);
          blank_mode = (c == lss_pkg::CH_SLASH) ? lss_pkg::MODE_LINE : lss_pkg::MODE_BLOCK;
        end else begin
          match_char(lss_pkg::CH_SLASH);
          match_char(c);
          blank_mode = lss_pkg::MODE_NORMAL;
        end
      end
      lss_pkg::MODE_LINE: begin
        if (c == lss_pkg::CH_NL) begin
          match_char(lss_pkg::CH_NL);
          blank_mode = lss_pkg::MODE_NORMAL;
        end else begin
          match_char(lss_pkg::CH_SPACE);
        end
      end
      lss_pkg::MODE_BLOCK: begin
        if (c == lss_pkg::CH_STAR) begin
          blank_mode = lss_pkg::MODE_STAR;
        end else begin
          match_char((c == lss_pkg::CH_NL) ? lss_pkg::CH_NL : lss_pkg::CH_SPACE);
        end
      end
      lss_pkg::MODE_STAR: begin
        if (c == lss_pkg::CH_SLASH) begin
          match_char(lss_pkg::CH_SPACE);
          match_char(lss_pkg::CH_SPACE);
          blank_mode = lss_pkg::MODE_NORMAL;
        end else begin
          match_char(lss_pkg::CH_SPACE);
          if (c != lss_pkg::CH_STAR) begin
            match_char((c == lss_pkg::CH_NL) ? lss_pkg::CH_NL : lss_pkg::CH_SPACE);
            blank_mode = lss_pkg::MODE_BLOCK;
          end
        end
      end
      default: begin
        if (c == lss_pkg::CH_SLASH) begin
          blank_mode = lss_pkg::MODE_SLASH;
        end else begin
          blank_mode = lss_pkg::MODE_NORMAL;
          match_char(c);
        end
      end
    endcase
  endtask

  task automatic take_byte(input logic [7:0] c, input logic fin);
    report_t     r;
    logic [95:0] prod;
    strip_char(c);
    if (fin) begin
      if (blank_mode == lss_pkg::MODE_SLASH) begin
        match_char(lss_pkg::CH_SLASH);
      end else if (blank_mode == lss_pkg::MODE_STAR) begin
        match_char(lss_pkg::CH_SPACE);
      end
      if (pat_pos == lss_pkg::POS_DIGITS) begin
        axis_val[cur_axis] = acc;
      end
      // full-width product, no wrap
      prod = {64'd0, axis_val[0]} * {64'd0, axis_val[1]} * {64'd0, axis_val[2]};
      r.x = axis_val[0];
      r.y = axis_val[1];
      r.z = axis_val[2];
      if (!seen_decl) begin
        r.verdict = lss_pkg::VERDICT_NONE;
      end else if (r.x > lim_x || r.y > lim_y || r.z > lim_z) begin
        r.verdict = lss_pkg::VERDICT_AXIS;
      end else if (prod > {64'd0, lim_inv}) begin
        r.verdict = lss_pkg::VERDICT_INVOKE;
      end else begin
        r.verdict = lss_pkg::VERDICT_OK;
      end
      pending_reports.insert(pending_reports.size(), r);
      clear_scan();
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------- sources
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      src_buf.insert(src_buf.size(), s[i]);
    end
  endtask

  task automatic add_ws(input int most);
    logic [7:0] w;
    repeat ($urandom_range(0, most)) begin
      w = $urandom_range(0, 1) ? lss_pkg::CH_SPACE
                               : 8'(lss_pkg::CH_TAB + $urandom_range(0, 4));
      src_buf.insert(src_buf.size(), w);
    end
  endtask

  task automatic add_number();
    logic [7:0] d;
    case ($urandom_range(0, 9))
      0: add_text("0");
      1: add_text($sformatf("00%0d", $urandom_range(1, 9)));
      2, 3, 4, 5: add_text($sformatf("%0d", $urandom_range(1, 64)));
      6: add_text($sformatf("%0d", $urandom_range(65, 5000)));
      7: add_text($sformatf("%0d", $urandom()));
      8: add_text($urandom_range(0, 1) ? "4294967295" : "4294967296");
      default: begin
        // well past 32 bits, must saturate
        d = 8'(lss_pkg::CH_0 + $urandom_range(1, 9));
        src_buf.insert(src_buf.size(), d);
        repeat ($urandom_range(10, 16)) begin
          d = 8'(lss_pkg::CH_0 + $urandom_range(0, 9));
          src_buf.insert(src_buf.size(), d);
        end
      end
    endcase
  endtask

  task automatic add_decl();
    logic [7:0] a;
    add_text(keyword);
    a = 8'(lss_pkg::CH_X + $urandom_range(0, 2));
    src_buf.insert(src_buf.size(), a);
    if ($urandom_range(0, 7) == 0) begin
      add_text("/**/");
    end else begin
      add_ws(2);
    end
    add_text("=");
    add_ws(2);
    add_number();
  endtask

  task automatic emit_source(input logic paced);
    job_t j;
    if (src_buf.size() == 0) begin
      src_buf.insert(0, lss_pkg::CH_SPACE);
    end
    foreach (src_buf[i]) begin
      j       = '0;
      j.kind  = JOB_BYTE;
      j.ch    = src_buf[i];
      j.last  = (i == src_buf.size() - 1);
      j.paced = paced;
      work_q.insert(work_q.size(), j);
    end
    byte_total += src_buf.size();
    src_buf.delete();
  endtask

  task automatic push_cfg(input logic [lss_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    job_t j;
    j      = '0;
    j.kind = JOB_CFG;
    j.idx  = idx;
    j.val  = val;
    work_q.insert(work_q.size(), j);
  endtask

  // ------------------------------------------------------------ monitor
  always @(posedge clk) begin : monitor
    report_t want;
    byte_taken = 1'b0;
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (cfg_index)
          lss_pkg::REG_MAX_X:   lim_x   = cfg_wdata;
          lss_pkg::REG_MAX_Y:   lim_y   = cfg_wdata;
          lss_pkg::REG_MAX_Z:   lim_z   = cfg_wdata;
          lss_pkg::REG_MAX_INV: lim_inv = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          check_field("verdict", {30'd0, want.verdict}, {30'd0, out_tdata[1:0]});
          check_field("size_x", want.x, out_tdata[33:2]);
          check_field("size_y", want.y, out_tdata[65:34]);
          check_field("size_z", want.z, out_tdata[97:66]);
          check_field("padding", 32'd0, {26'd0, out_tdata[lss_pkg::OUT_DATA_W-1:98]});
        end
      end
      if (in_tvalid && in_tready) begin
        byte_taken = 1'b1;
        take_byte(in_tdata, in_tlast);
      end
    end
  end

  // ------------------------------------------------------------- driver
  always @(negedge clk) begin : driver
    logic offer;
    logic wr;
    job_t job;
    offer = in_tvalid && !byte_taken;
    wr    = 1'b0;
    if (rst_n && !offer) begin
      if (settle_left > 0) begin
        settle_left--;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (work_q.size() > 0) begin
        job = work_q[0];
        case (job.kind)
          JOB_BYTE: begin
            offer    = 1'b1;
            in_tdata <= job.ch;
            in_tlast <= job.last;
            gap_left = (job.paced && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
            work_q.delete(0);
          end
          JOB_SYNC: begin
            // hold until every report is out, then let the block go quiet
            if (pending_reports.size() == 0) begin
              settle_left = SETTLE_CYCLES;
              work_q.delete(0);
            end
          end
          default: begin
            wr        = 1'b1;
            cfg_index <= job.idx;
            cfg_wdata <= job.val;
            work_q.delete(0);
          end
        endcase
      end
    end
    in_tvalid <= offer;
    cfg_wr_en <= wr;
  end

  // ----------------------------------------------------------- receiver
  always @(negedge clk) begin : receiver
    logic take;
    take = 1'b1;
    if (rx_phase_left == 0) begin
      rx_calm       = ($urandom_range(0, 3) == 0);
      rx_phase_left = $urandom_range(200, 800);
    end else begin
      rx_phase_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      take = 1'b0;
    end else if (!hold_done && results_seen >= 10 && work_q.size() > 60 &&
                 work_q[0].kind == JOB_BYTE) begin
      // one long back-pressure stretch while sources keep coming
      hold_done = 1'b1;
      hold_left = 400;
      take      = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      take = 1'b0;
    end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
      stall_left = pick_gap() - 1;
      take       = 1'b0;
    end
    out_tready <= take;
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------- stimulus
  initial begin : stimulus
    int          phase;
    int          pick;
    logic        paced;
    logic [7:0]  b;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] vi;
    job_t        j;

    // directed, at reset limits
    add_text({keyword, "z=65"});     // z over its limit
    emit_source(1'b0);
    src_buf.insert(src_buf.size(), 8'h00);
    emit_source(1'b0);
    src_buf.insert(src_buf.size(), 8'hFF);
    emit_source(1'b0);
    add_text("/");                   // ends on a held slash
    emit_source(1'b0);
    add_text("/**");                 // ends on a held star in a block comment
    emit_source(1'b0);

    phase = 0;
    while (byte_total < TARGET_BYTES) begin
      pick = (phase < 3) ? phase : $urandom_range(2, 6);
      case (pick)
        0: begin
          vx = '0; vy = '0; vz = '0; vi = '0;
        end
        1: begin
          vx = '1; vy = '1; vz = '1; vi = '1;
        end
        2: begin
          vx = lss_pkg::RST_MAX_X; vy = lss_pkg::RST_MAX_Y;
          vz = lss_pkg::RST_MAX_Z; vi = lss_pkg::RST_MAX_INV;
        end
        3: begin
          vx = $urandom_range(1, 128);
          vy = $urandom_range(1, 128);
          vz = $urandom_range(1, 128);
          vi = $urandom_range(1, 100000);
        end
        4: begin
          vx = $urandom(); vy = $urandom(); vz = $urandom(); vi = $urandom();
        end
        default: begin
          // axes wide open, product limit decides
          vx = '1; vy = '1; vz = '1;
          vi = $urandom_range(1, 5000);
        end
      endcase
      j      = '0;
      j.kind = JOB_SYNC;
      work_q.insert(work_q.size(), j);
      push_cfg(lss_pkg::REG_MAX_X, vx);
      push_cfg(lss_pkg::REG_MAX_Y, vy);
      push_cfg(lss_pkg::REG_MAX_Z, vz);
      push_cfg(lss_pkg::REG_MAX_INV, vi);

      paced = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(6, 12)) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6: add_decl();
            7: add_text("layout(");
            8: add_text("void main() { v = a/b * c; }\n");
            9: add_text($urandom_range(0, 1) ? {"local", keyword, "y=5"}
                                             : {"loca", keyword, "z = 2"});
            10: begin
              add_text($urandom_range(0, 1) ? {keyword, "w="} : {keyword, "x = y"});
              add_number();
            end
            11: begin
              add_text("//");
              add_decl();
              add_text($urandom_range(0, 1) ? "\n" : "\r\n");
            end
            12: begin
              add_text("/* ");
              add_decl();
              add_text(" **\n*/");
            end
            13: add_text("/*/ * **/");
            default: begin
              repeat ($urandom_range(1, 4)) begin
                b = 8'($urandom_range(0, 255));
                src_buf.insert(src_buf.size(), b);
              end
            end
          endcase
          case ($urandom_range(0, 2))
            0: ;
            1: add_ws(3);
            default: add_text(";\n");
          endcase
        end
        case ($urandom_range(0, 19))
          0: add_text("/");
          1: add_text("/* tail *");
          2: add_text("// open");
          3: add_text("/* open");
          4: add_text("*");
          default: ;
        endcase
        emit_source(paced);
        if ($urandom_range(0, 5) == 0) begin
          paced = !paced;
        end
      end
      phase++;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (work_q.size() != 0 || in_tvalid || pending_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
